// ===== rtl/core/sphere_contact_force_unit_assert.svh =====
// assertion macros shared by the sphere contact force rtl
// no dependencies; included by the files that check their own logic
`ifndef SPHERE_CONTACT_FORCE_UNIT_ASSERT_SVH
`define SPHERE_CONTACT_FORCE_UNIT_ASSERT_SVH

// same-cycle implication
`define SCF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sphere contact force check failed");

// next-cycle implication
`define SCF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sphere contact force check failed");

`endif

// ===== rtl/core/scf_pkg.sv =====
// shared constants and types of the sphere contact force unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int COEF_BITS      = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_IDX_BITS   = 2;

   // normalized distance components carry their msb here
   localparam int NORM_MSB   = 30;
   localparam int NORM_BITS  = 31;
   localparam int SUM_BITS   = 64;
   localparam int ROOT_BITS  = 32;
   localparam int SQRT_STEPS = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPRING  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DAMPING = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHEAR   = 2'd2;

   localparam logic [COEF_BITS-1:0] SPRING_RESET  = 16'd328;
   localparam logic [COEF_BITS-1:0] DAMPING_RESET = 16'd131;
   localparam logic [COEF_BITS-1:0] SHEAR_RESET   = 16'd66;

   typedef struct packed {
      logic [COEF_BITS-1:0] spring;
      logic [COEF_BITS-1:0] damping;
      logic [COEF_BITS-1:0] shear;
   } scf_coef_type;

endpackage

`default_nettype wire

// ===== rtl/core/scf_chan_if.sv =====
// request and response channel interfaces of the sphere contact force unit
// depends on scf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface scf_req_if #(parameter int W = scf_pkg::WORD_WIDTH_DEF) ();
   logic                valid;
   logic                ready;
   logic                op;
   logic signed [W-1:0] pos_x;
   logic signed [W-1:0] pos_y;
   logic signed [W-1:0] pos_z;
   logic signed [W-1:0] vel_x;
   logic signed [W-1:0] vel_y;
   logic signed [W-1:0] vel_z;
   logic [W-2:0]        radius;

   modport source (output valid, op, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius,
                   input ready);
   modport sink (input valid, op, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius,
                 output ready);
endinterface

interface scf_rsp_if #(parameter int W = scf_pkg::WORD_WIDTH_DEF) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] force_x;
   logic signed [W-1:0] force_y;
   logic signed [W-1:0] force_z;
   logic                in_contact;

   modport source (output valid, force_x, force_y, force_z, in_contact, input ready);
   modport sink (input valid, force_x, force_y, force_z, in_contact, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scf_front.sv =====
// front end: accepts items, holds the reference sphere and coefficients,
// forms the difference vectors of a query; depends on scf_pkg, scf_chan_if
`timescale 1ns / 1ps
`default_nettype none

module scf_front #(
   parameter int W = scf_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   scf_req_if.sink                                req,
   input  wire logic                              csr_we,
   input  wire logic [scf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [scf_pkg::COEF_BITS-1:0]     csr_wdata,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output logic [6*(W+1)+W-1:0]                   q_data,
   output scf_pkg::scf_coef_type                  coef
);

   localparam int MW = W + 1;

   logic signed [W-1:0]   ref_pos_ff [3];
   logic signed [W-1:0]   ref_vel_ff [3];
   logic [W-2:0]          ref_rad_ff;
   scf_pkg::scf_coef_type coef_ff;
   scf_pkg::scf_coef_type coef_in;

   logic                  accept;
   logic signed [W-1:0]   pos [3];
   logic signed [W-1:0]   vel [3];
   logic signed [MW-1:0]  d [3];
   logic signed [MW-1:0]  dv [3];
   logic [W-1:0]          rsum;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign coef      = coef_ff;

   assign pos[0] = req.pos_x;
   assign pos[1] = req.pos_y;
   assign pos[2] = req.pos_z;
   assign vel[0] = req.vel_x;
   assign vel[1] = req.vel_y;
   assign vel[2] = req.vel_z;

   always_comb begin
      rsum = W'(ref_rad_ff) + W'(req.radius);
      q_data = '0;
      for (int i = 0; i < 3; i++) begin
         d[i]  = MW'(ref_pos_ff[i]) - MW'(pos[i]);
         dv[i] = MW'(ref_vel_ff[i]) - MW'(vel[i]);
         q_data[W + i*MW +: MW]        = dv[i];
         q_data[W + 3*MW + i*MW +: MW] = d[i];
      end
      q_data[W-1:0] = rsum;
   end

   assign q_push = accept && (req.op == scf_pkg::OP_QUERY);

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         case (csr_index)
            scf_pkg::CSR_SPRING:  coef_in.spring  = csr_wdata;
            scf_pkg::CSR_DAMPING: coef_in.damping = csr_wdata;
            scf_pkg::CSR_SHEAR:   coef_in.shear   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.spring  <= scf_pkg::SPRING_RESET;
         coef_ff.damping <= scf_pkg::DAMPING_RESET;
         coef_ff.shear   <= scf_pkg::SHEAR_RESET;
         ref_rad_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            ref_pos_ff[i] <= '0;
            ref_vel_ff[i] <= '0;
         end
      end else begin
         coef_ff <= coef_in;
         if (accept && req.op == scf_pkg::OP_LOAD) begin
            ref_rad_ff <= req.radius;
            for (int i = 0; i < 3; i++) begin
               ref_pos_ff[i] <= pos[i];
               ref_vel_ff[i] <= vel[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/scf_queue.sv =====
// short register queue between the front end and the force pipeline
// depends on scf_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_contact_force_unit_assert.svh"

module scf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = scf_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  empty,
   output logic                  full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop) rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `SCF_ASSERT_NEXT(a_queue_fill, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)
   `SCF_ASSERT_NOW(a_queue_ptrs, clock, reset, empty, wr_ptr_ff == rd_ptr_ff)

endmodule

`default_nettype wire

// ===== rtl/core/scf_mulsh.sv =====
// sign-magnitude multiply by an unsigned factor, shifted right, truncated toward zero
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module scf_mulsh #(
   parameter int AW = 33,
   parameter int BW = 16,
   parameter int SH = 16
) (
   input  wire logic signed [AW-1:0] a,
   input  wire logic [BW-1:0]        b,
   input  wire logic                 neg,
   output logic signed [AW:0]        y
);

   localparam int PW = AW + BW;

   logic [AW-1:0] mag;
   logic [PW-1:0] prod;
   logic [AW:0]   res;

   always_comb begin
      mag  = a[AW-1] ? AW'(-a) : AW'(a);
      prod = PW'(mag) * PW'(b);
      res  = (AW+1)'(prod >> SH);
      y    = (a[AW-1] ^ neg) ? -signed'(res) : signed'(res);
   end

endmodule

`default_nettype wire

// ===== rtl/core/scf_back.sv =====
// force pipeline: normalize, square root, normal division, force terms
// depends on scf_pkg, scf_chan_if, scf_mulsh and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_contact_force_unit_assert.svh"

module scf_back #(
   parameter int F = scf_pkg::FRAC_BITS_DEF,
   parameter int W = scf_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [6*(W+1)+W-1:0]  q_data,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   input  wire scf_pkg::scf_coef_type coef,
   scf_rsp_if.source                  rsp
);

   localparam int MW  = W + 1;
   localparam int KW  = $clog2(MW + 32);
   localparam int NQ  = scf_pkg::NORM_BITS;
   localparam int SW  = MW + NQ;
   localparam int NS  = scf_pkg::SQRT_STEPS;
   localparam int RB  = scf_pkg::ROOT_BITS;
   localparam int XB  = scf_pkg::SUM_BITS;
   localparam int NB  = F + 1;
   localparam int DW  = RB + F + 1;
   localparam int XW  = RB + MW;
   localparam int CB  = scf_pkg::COEF_BITS;
   localparam logic signed [W+7:0] SAT_HI = (W+8)'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [W+7:0] SAT_LO = -SAT_HI - 1;

   logic en;
   logic out_v_ff;

   assign en        = !out_v_ff || rsp.ready;
   assign q_pop     = en && !q_empty;
   assign rsp.valid = out_v_ff;

   // stage 0: item from the queue
   logic                 v0_ff;
   logic signed [MW-1:0] d0_ff [3];
   logic signed [MW-1:0] dv0_ff [3];
   logic [W-1:0]         rsum0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsum0_ff <= q_data[W-1:0];
         for (int i = 0; i < 3; i++) begin
            dv0_ff[i] <= q_data[W + i*MW +: MW];
            d0_ff[i]  <= q_data[W + 3*MW + i*MW +: MW];
         end
      end
   end

   // stage 1: magnitudes and largest one
   logic                 v1_ff;
   logic [MW-1:0]        mag1_ff [3];
   logic [MW-1:0]        maxm1_ff;
   logic [2:0]           dsg1_ff;
   logic signed [MW-1:0] dv1_ff [3];
   logic [W-1:0]         rsum1_ff;
   logic [MW-1:0]        mag0 [3];
   logic [MW-1:0]        maxm0;

   always_comb begin
      maxm0 = '0;
      for (int i = 0; i < 3; i++) begin
         mag0[i] = d0_ff[i][MW-1] ? MW'(-d0_ff[i]) : MW'(d0_ff[i]);
         if (mag0[i] > maxm0) maxm0 = mag0[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         maxm1_ff <= maxm0;
         rsum1_ff <= rsum0_ff;
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag0[i];
            dsg1_ff[i] <= d0_ff[i][MW-1];
            dv1_ff[i]  <= dv0_ff[i];
         end
      end
   end

   // stage 2: leading one position
   logic                 v2_ff;
   logic [MW-1:0]        mag2_ff [3];
   logic [KW-1:0]        p2_ff;
   logic                 zero2_ff;
   logic [2:0]           dsg2_ff;
   logic signed [MW-1:0] dv2_ff [3];
   logic [W-1:0]         rsum2_ff;
   logic [KW-1:0]        p1;

   always_comb begin
      p1 = '0;
      for (int b = 0; b < MW; b++) begin
         if (maxm1_ff[b]) p1 = KW'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff    <= p1;
         zero2_ff <= (maxm1_ff == '0);
         dsg2_ff  <= dsg1_ff;
         rsum2_ff <= rsum1_ff;
         for (int i = 0; i < 3; i++) begin
            mag2_ff[i] <= mag1_ff[i];
            dv2_ff[i]  <= dv1_ff[i];
         end
      end
   end

   // stage 3: normalizing shift
   logic                 v3_ff;
   logic [NQ-1:0]        dd3_ff [3];
   logic [KW-1:0]        k3_ff;
   logic                 down3_ff;
   logic                 zero3_ff;
   logic [2:0]           dsg3_ff;
   logic signed [MW-1:0] dv3_ff [3];
   logic [W-1:0]         rsum3_ff;
   logic                 rshift2;
   logic [KW-1:0]        k2;

   always_comb begin
      rshift2 = (p2_ff >= KW'(scf_pkg::NORM_MSB));
      k2      = rshift2 ? p2_ff - KW'(scf_pkg::NORM_MSB) : KW'(scf_pkg::NORM_MSB) - p2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k3_ff    <= k2;
         down3_ff <= (p2_ff > KW'(scf_pkg::NORM_MSB));
         zero3_ff <= zero2_ff;
         dsg3_ff  <= dsg2_ff;
         rsum3_ff <= rsum2_ff;
         for (int i = 0; i < 3; i++) begin
            dd3_ff[i] <= rshift2 ? NQ'(mag2_ff[i] >> k2) : NQ'(SW'(mag2_ff[i]) << k2);
            dv3_ff[i] <= dv2_ff[i];
         end
      end
   end

   // stage 4: squares
   logic                 v4_ff;
   logic [2*NQ-1:0]      sq4_ff [3];
   logic [NQ-1:0]        dd4_ff [3];
   logic [KW-1:0]        k4_ff;
   logic                 down4_ff;
   logic                 zero4_ff;
   logic [2:0]           dsg4_ff;
   logic signed [MW-1:0] dv4_ff [3];
   logic [W-1:0]         rsum4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         k4_ff    <= k3_ff;
         down4_ff <= down3_ff;
         zero4_ff <= zero3_ff;
         dsg4_ff  <= dsg3_ff;
         rsum4_ff <= rsum3_ff;
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= (2*NQ)'(dd3_ff[i]) * (2*NQ)'(dd3_ff[i]);
            dd4_ff[i] <= dd3_ff[i];
            dv4_ff[i] <= dv3_ff[i];
         end
      end
   end

   // square root, one result bit per stage; index 0 holds the sum of squares
   logic                 sq_v_ff    [NS+1];
   logic [XB-1:0]        sq_x_ff    [NS+1];
   logic [RB+1:0]        sq_rem_ff  [NS+1];
   logic [RB-1:0]        sq_root_ff [NS+1];
   logic [NQ-1:0]        sq_dd_ff   [NS+1][3];
   logic [KW-1:0]        sq_k_ff    [NS+1];
   logic                 sq_down_ff [NS+1];
   logic                 sq_zero_ff [NS+1];
   logic [2:0]           sq_dsg_ff  [NS+1];
   logic signed [MW-1:0] sq_dv_ff   [NS+1][3];
   logic [W-1:0]         sq_rsum_ff [NS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff[0]    <= XB'(sq4_ff[0]) + XB'(sq4_ff[1]) + XB'(sq4_ff[2]);
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_k_ff[0]    <= k4_ff;
         sq_down_ff[0] <= down4_ff;
         sq_zero_ff[0] <= zero4_ff;
         sq_dsg_ff[0]  <= dsg4_ff;
         sq_rsum_ff[0] <= rsum4_ff;
         for (int i = 0; i < 3; i++) begin
            sq_dd_ff[0][i] <= dd4_ff[i];
            sq_dv_ff[0][i] <= dv4_ff[i];
         end
      end
   end

   for (genvar j = 1; j <= NS; j++) begin : g_sqrt
      logic [RB+3:0] rs;
      logic [RB+3:0] tr;
      logic          ge;

      always_comb begin
         rs = {sq_rem_ff[j-1], sq_x_ff[j-1][XB-1:XB-2]};
         tr = (RB+4)'({sq_root_ff[j-1], 2'b01});
         ge = (rs >= tr);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j] <= 1'b0;
         end else if (en) begin
            sq_v_ff[j] <= sq_v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_x_ff[j]    <= sq_x_ff[j-1] << 2;
            sq_rem_ff[j]  <= ge ? (RB+2)'(rs - tr) : rs[RB+1:0];
            sq_root_ff[j] <= {sq_root_ff[j-1][RB-2:0], ge};
            sq_k_ff[j]    <= sq_k_ff[j-1];
            sq_down_ff[j] <= sq_down_ff[j-1];
            sq_zero_ff[j] <= sq_zero_ff[j-1];
            sq_dsg_ff[j]  <= sq_dsg_ff[j-1];
            sq_rsum_ff[j] <= sq_rsum_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               sq_dd_ff[j][i] <= sq_dd_ff[j-1][i];
               sq_dv_ff[j][i] <= sq_dv_ff[j-1][i];
            end
         end
      end
   end

   // contact test and overlap; index 0 of the divider holds it
   logic                 dq_v_ff    [NB+1];
   logic [RB-1:0]        dq_q_ff    [NB+1];
   logic [DW-1:0]        dq_rem_ff  [NB+1][3];
   logic [NB-1:0]        dq_quot_ff [NB+1][3];
   logic                 dq_zero_ff [NB+1];
   logic                 dq_cont_ff [NB+1];
   logic [W-1:0]         dq_ov_ff   [NB+1];
   logic [2:0]           dq_dsg_ff  [NB+1];
   logic signed [MW-1:0] dq_dv_ff   [NB+1][3];

   logic [RB-1:0]  root_c;
   logic [KW-1:0]  k_c;
   logic [XW-1:0]  rsum_c;
   logic [XW-1:0]  dist_c;
   logic [XW-1:0]  whole_c;
   logic [XW-1:0]  up_c;
   logic [RB-1:0]  fmask_c;
   logic           cont_c;
   logic [XW-1:0]  ov_c;

   always_comb begin
      root_c  = sq_root_ff[NS];
      k_c     = sq_k_ff[NS];
      rsum_c  = XW'(sq_rsum_ff[NS]);
      dist_c  = XW'(root_c) << k_c;
      whole_c = XW'(root_c >> k_c);
      fmask_c = (RB'(1) << k_c) - 1'b1;
      up_c    = whole_c + XW'((root_c & fmask_c) != '0);
      priority if (sq_zero_ff[NS]) begin
         cont_c = (rsum_c != '0);
         ov_c   = rsum_c;
      end else if (sq_down_ff[NS]) begin
         cont_c = (dist_c < rsum_c);
         ov_c   = rsum_c - dist_c;
      end else begin
         cont_c = (whole_c < rsum_c);
         ov_c   = rsum_c - up_c;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dq_q_ff[0]    <= root_c;
         dq_zero_ff[0] <= sq_zero_ff[NS];
         dq_cont_ff[0] <= cont_c;
         dq_ov_ff[0]   <= W'(ov_c);
         dq_dsg_ff[0]  <= sq_dsg_ff[NS];
         for (int i = 0; i < 3; i++) begin
            dq_rem_ff[0][i]  <= DW'(sq_dd_ff[NS][i]) << F;
            dq_quot_ff[0][i] <= '0;
            dq_dv_ff[0][i]   <= sq_dv_ff[NS][i];
         end
      end
   end

   // normal components by restoring division, one quotient bit per stage
   for (genvar j = 1; j <= NB; j++) begin : g_div
      logic [DW-1:0] tr;
      logic [DW-1:0] rem_n [3];
      logic [2:0]    ge;

      always_comb begin
         tr = DW'(dq_q_ff[j-1]) << (NB - j);
         for (int i = 0; i < 3; i++) begin
            ge[i]    = (dq_rem_ff[j-1][i] >= tr);
            rem_n[i] = ge[i] ? dq_rem_ff[j-1][i] - tr : dq_rem_ff[j-1][i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dq_v_ff[j] <= 1'b0;
         end else if (en) begin
            dq_v_ff[j] <= dq_v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dq_q_ff[j]    <= dq_q_ff[j-1];
            dq_zero_ff[j] <= dq_zero_ff[j-1];
            dq_cont_ff[j] <= dq_cont_ff[j-1];
            dq_ov_ff[j]   <= dq_ov_ff[j-1];
            dq_dsg_ff[j]  <= dq_dsg_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               dq_rem_ff[j][i]  <= rem_n[i];
               dq_quot_ff[j][i] <= {dq_quot_ff[j-1][i][NB-2:0], ge[i]};
               dq_dv_ff[j][i]   <= dq_dv_ff[j-1][i];
            end
         end
      end
   end

   // force stage 1: velocity projections, damping and spring factor
   logic [NB-1:0]        nm_e [3];
   logic signed [W+1:0]  t_c [3];
   logic signed [W+1:0]  damp_c [3];
   logic signed [W+1:0]  fac_c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm_e[i] = dq_zero_ff[NB] ? '0 : dq_quot_ff[NB][i];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_f1
      scf_mulsh #(.AW(MW), .BW(NB), .SH(F)) u_proj (
         .a(dq_dv_ff[NB][i]), .b(nm_e[i]), .neg(dq_dsg_ff[NB][i]), .y(t_c[i]));
      scf_mulsh #(.AW(MW), .BW(CB), .SH(CB)) u_damp (
         .a(dq_dv_ff[NB][i]), .b(coef.damping), .neg(1'b0), .y(damp_c[i]));
   end

   scf_mulsh #(.AW(W+1), .BW(CB), .SH(CB)) u_spring (
      .a(signed'({1'b0, dq_ov_ff[NB]})), .b(coef.spring), .neg(1'b1), .y(fac_c));

   logic                 f1_v_ff;
   logic signed [W+1:0]  t1_ff [3];
   logic signed [W+1:0]  damp1_ff [3];
   logic signed [W+1:0]  fac1_ff;
   logic [NB-1:0]        nm1_ff [3];
   logic [2:0]           dsg1f_ff;
   logic signed [MW-1:0] dv1f_ff [3];
   logic                 cont1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fac1_ff  <= fac_c;
         dsg1f_ff <= dq_dsg_ff[NB];
         cont1_ff <= dq_cont_ff[NB];
         for (int i = 0; i < 3; i++) begin
            t1_ff[i]    <= t_c[i];
            damp1_ff[i] <= damp_c[i];
            nm1_ff[i]   <= nm_e[i];
            dv1f_ff[i]  <= dq_dv_ff[NB][i];
         end
      end
   end

   // force stage 2: dot product and normal force
   logic signed [W+2:0]  fn_c [3];

   for (genvar i = 0; i < 3; i++) begin : g_f2
      scf_mulsh #(.AW(W+2), .BW(NB), .SH(F)) u_fn (
         .a(fac1_ff), .b(nm1_ff[i]), .neg(dsg1f_ff[i]), .y(fn_c[i]));
   end

   logic                 f2_v_ff;
   logic signed [W+3:0]  vdn2_ff;
   logic signed [W+2:0]  fn2_ff [3];
   logic signed [W+1:0]  damp2_ff [3];
   logic [NB-1:0]        nm2_ff [3];
   logic [2:0]           dsg2f_ff;
   logic signed [MW-1:0] dv2f_ff [3];
   logic                 cont2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         vdn2_ff  <= (W+4)'(t1_ff[0]) + (W+4)'(t1_ff[1]) + (W+4)'(t1_ff[2]);
         dsg2f_ff <= dsg1f_ff;
         cont2_ff <= cont1_ff;
         for (int i = 0; i < 3; i++) begin
            fn2_ff[i]   <= fn_c[i];
            damp2_ff[i] <= damp1_ff[i];
            nm2_ff[i]   <= nm1_ff[i];
            dv2f_ff[i]  <= dv1f_ff[i];
         end
      end
   end

   // force stage 3: normal part of relative velocity
   logic signed [W+4:0]  vn_c [3];

   for (genvar i = 0; i < 3; i++) begin : g_f3
      scf_mulsh #(.AW(W+4), .BW(NB), .SH(F)) u_vn (
         .a(vdn2_ff), .b(nm2_ff[i]), .neg(dsg2f_ff[i]), .y(vn_c[i]));
   end

   logic                 f3_v_ff;
   logic signed [W+4:0]  vn3_ff [3];
   logic signed [W+2:0]  fn3_ff [3];
   logic signed [W+1:0]  damp3_ff [3];
   logic signed [MW-1:0] dv3f_ff [3];
   logic                 cont3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cont3_ff <= cont2_ff;
         for (int i = 0; i < 3; i++) begin
            vn3_ff[i]   <= vn_c[i];
            fn3_ff[i]   <= fn2_ff[i];
            damp3_ff[i] <= damp2_ff[i];
            dv3f_ff[i]  <= dv2f_ff[i];
         end
      end
   end

   // force stage 4: tangential velocity
   logic                 f4_v_ff;
   logic signed [W+5:0]  tv4_ff [3];
   logic signed [W+2:0]  fn4_ff [3];
   logic signed [W+1:0]  damp4_ff [3];
   logic                 cont4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cont4_ff <= cont3_ff;
         for (int i = 0; i < 3; i++) begin
            tv4_ff[i]   <= (W+6)'(dv3f_ff[i]) - (W+6)'(vn3_ff[i]);
            fn4_ff[i]   <= fn3_ff[i];
            damp4_ff[i] <= damp3_ff[i];
         end
      end
   end

   // force stage 5: shear term
   logic signed [W+6:0]  sh_c [3];

   for (genvar i = 0; i < 3; i++) begin : g_f5
      scf_mulsh #(.AW(W+6), .BW(CB), .SH(CB)) u_shear (
         .a(tv4_ff[i]), .b(coef.shear), .neg(1'b0), .y(sh_c[i]));
   end

   logic                 f5_v_ff;
   logic signed [W+6:0]  sh5_ff [3];
   logic signed [W+2:0]  fn5_ff [3];
   logic signed [W+1:0]  damp5_ff [3];
   logic                 cont5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cont5_ff <= cont4_ff;
         for (int i = 0; i < 3; i++) begin
            sh5_ff[i]   <= sh_c[i];
            fn5_ff[i]   <= fn4_ff[i];
            damp5_ff[i] <= damp4_ff[i];
         end
      end
   end

   // output register: sum, saturate, zero when apart
   logic signed [W+7:0]  tot_c [3];
   logic signed [W-1:0]  sat_c [3];
   logic signed [W-1:0]  force_ff [3];
   logic                 contact_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tot_c[i] = (W+8)'(fn5_ff[i]) + (W+8)'(damp5_ff[i]) + (W+8)'(sh5_ff[i]);
         priority if (!cont5_ff) sat_c[i] = '0;
         else if (tot_c[i] > SAT_HI) sat_c[i] = W'(SAT_HI);
         else if (tot_c[i] < SAT_LO) sat_c[i] = W'(SAT_LO);
         else sat_c[i] = W'(tot_c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         contact_ff <= cont5_ff;
         for (int i = 0; i < 3; i++) begin
            force_ff[i] <= sat_c[i];
         end
      end
   end

   assign rsp.force_x    = force_ff[0];
   assign rsp.force_y    = force_ff[1];
   assign rsp.force_z    = force_ff[2];
   assign rsp.in_contact = contact_ff;

   // valid chain of the fixed stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff      <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         sq_v_ff[0] <= 1'b0;
         dq_v_ff[0] <= 1'b0;
         f1_v_ff    <= 1'b0;
         f2_v_ff    <= 1'b0;
         f3_v_ff    <= 1'b0;
         f4_v_ff    <= 1'b0;
         f5_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else if (en) begin
         v0_ff      <= !q_empty;
         v1_ff      <= v0_ff;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         sq_v_ff[0] <= v4_ff;
         dq_v_ff[0] <= sq_v_ff[NS];
         f1_v_ff    <= dq_v_ff[NB];
         f2_v_ff    <= f1_v_ff;
         f3_v_ff    <= f2_v_ff;
         f4_v_ff    <= f3_v_ff;
         f5_v_ff    <= f4_v_ff;
         out_v_ff   <= f5_v_ff;
      end
   end

   `SCF_ASSERT_NEXT(a_stall_freezes, clock, reset, !en, $stable(v4_ff) && $stable(f3_v_ff))
   `SCF_ASSERT_NOW(a_apart_zero, clock, reset, out_v_ff && !contact_ff, force_ff[0] == '0 && force_ff[1] == '0 && force_ff[2] == '0)

endmodule

`default_nettype wire

// ===== rtl/core/sphere_contact_force_unit.sv =====
// top level of the sphere contact force unit
// depends on scf_pkg, scf_chan_if, scf_front, scf_queue, scf_back
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        op, pos_xyz, vel_xyz, radius
//   rsp_bus   out        valid/ready        force_xyz, in_contact
//   csr_*     in         csr_we, no ready   csr_index, csr_wdata
//
// one item per cycle while the queue is not full; a query result passes through
// the 32-stage square root and the FRAC_BITS+1 stage normal divider
// load items update the reference sphere at acceptance and give no result
// reset clears reference sphere to zero and coefficients to their defaults at once
// when a result is not taken the whole force pipeline holds; the 4-entry queue
// keeps the request side open until it fills
`timescale 1ns / 1ps
`default_nettype none

module sphere_contact_force_unit #(
   parameter int FRAC_BITS  = scf_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = scf_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   scf_req_if.sink                               req_bus,
   scf_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_we,
   input  wire logic [scf_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [scf_pkg::COEF_BITS-1:0]    csr_wdata
);

   localparam int EW = 6 * (WORD_WIDTH + 1) + WORD_WIDTH;

   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_empty;
   logic [EW-1:0]         q_in;
   logic [EW-1:0]         q_head;
   scf_pkg::scf_coef_type coef;

   scf_front #(.W(WORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in),
      .coef      (coef)
   );

   scf_queue #(.WIDTH(EW), .DEPTH(scf_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   scf_back #(.F(FRAC_BITS), .W(WORD_WIDTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .coef    (coef),
      .rsp     (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== tb/scf_force_checker.sv =====
// checker of the sphere contact force unit: predicts each query result and compares
// depends on scf_pkg and scf_chan_if; watches the channels and the csr port
`timescale 1ns / 1ps

module scf_force_checker (
   input  logic                             clock,
   input  logic                             reset,
   scf_req_if                               req,
   scf_rsp_if                               rsp,
   input  logic                             csr_we,
   input  logic [scf_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [scf_pkg::COEF_BITS-1:0]    csr_wdata,
   output int                               fail_count,
   output int                               pending
);

   localparam int FB = scf_pkg::FRAC_BITS_DEF;

   typedef struct {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
      logic               contact;
   } force_result_type;

   force_result_type expected_forces[$];

   logic [15:0]  spring, damping, shear;
   longint       ref_pos[3];
   longint       ref_vel[3];
   longint unsigned ref_rad;

   // truncate toward zero after the shift
   function automatic longint mul_shift(longint a, longint unsigned b, int s);
      longint unsigned m, lo, r;
      m  = (a < 0) ? longint'(-a) : a;
      lo = m & ((64'd1 << s) - 1);
      r  = (m >> s) * b + ((lo * b) >> s);
      return (a < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint mul_norm(longint a, longint n);
      longint p;
      p = mul_shift(a, (n < 0) ? longint'(-n) : n, FB);
      return (n < 0) ? -p : p;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bits;
      res  = 0;
      bits = 64'd1 << 62;
      while (bits > x) bits = bits >> 2;
      while (bits != 0) begin
         if (x >= res + bits) begin
            x   = x - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] clamp_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic force_result_type contact_force(longint p[3], longint v[3],
                                                      longint unsigned rad);
      force_result_type res;
      longint          d[3], dv[3], nrm[3], tv[3], ov, vdn, fac, f[3];
      longint unsigned mag[3], dd[3], maxm, sum, q, rsum, sep, whole, up;
      int              k;
      logic            contact, down;
      ov   = 0;
      maxm = 0;
      sum  = 0;
      k    = 0;
      rsum = ref_rad + rad;
      for (int i = 0; i < 3; i++) begin
         d[i]   = ref_pos[i] - p[i];
         dv[i]  = ref_vel[i] - v[i];
         mag[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
         if (mag[i] > maxm) maxm = mag[i];
         nrm[i] = 0;
      end
      if (maxm == 0) begin
         // coincident centres: no normal, overlap is the whole radius sum
         contact = rsum > 0;
         ov      = rsum;
      end else begin
         down = maxm >= (64'd1 << 31);
         if (down) begin
            while ((maxm >> k) >= (64'd1 << 31)) k++;
         end else begin
            while ((maxm << k) < (64'd1 << 30)) k++;
         end
         for (int i = 0; i < 3; i++) begin
            dd[i] = down ? (mag[i] >> k) : (mag[i] << k);
            sum  += dd[i] * dd[i];
         end
         q = int_sqrt(sum);
         if (down) begin
            sep     = q << k;
            contact = sep < rsum;
            if (contact) ov = rsum - sep;
         end else begin
            whole   = q >> k;
            up      = whole + (((q & ((64'd1 << k) - 1)) != 0) ? 1 : 0);
            contact = whole < rsum;
            if (contact) ov = longint'(rsum) - longint'(up);
         end
         for (int i = 0; i < 3; i++) begin
            nrm[i] = (dd[i] << FB) / q;
            if (d[i] < 0) nrm[i] = -nrm[i];
         end
      end
      res.fx = 0;
      res.fy = 0;
      res.fz = 0;
      res.contact = contact;
      if (contact) begin
         vdn = 0;
         for (int i = 0; i < 3; i++) vdn += mul_norm(dv[i], nrm[i]);
         for (int i = 0; i < 3; i++) tv[i] = dv[i] - mul_norm(vdn, nrm[i]);
         fac = -mul_shift(ov, 64'(spring), scf_pkg::COEF_BITS);
         for (int i = 0; i < 3; i++)
            f[i] = mul_norm(fac, nrm[i])
                   + mul_shift(dv[i], 64'(damping), scf_pkg::COEF_BITS)
                   + mul_shift(tv[i], 64'(shear), scf_pkg::COEF_BITS);
         res.fx = clamp_word(f[0]);
         res.fy = clamp_word(f[1]);
         res.fz = clamp_word(f[2]);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      force_result_type exp_r;
      longint           p[3], v[3];
      if (reset) begin
         spring  = scf_pkg::SPRING_RESET;
         damping = scf_pkg::DAMPING_RESET;
         shear   = scf_pkg::SHEAR_RESET;
         for (int i = 0; i < 3; i++) begin
            ref_pos[i] = 0;
            ref_vel[i] = 0;
         end
         ref_rad = 0;
         expected_forces.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               scf_pkg::CSR_SPRING:  spring  = csr_wdata;
               scf_pkg::CSR_DAMPING: damping = csr_wdata;
               scf_pkg::CSR_SHEAR:   shear   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_forces.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               exp_r = expected_forces.pop_front();
               if (rsp.force_x !== exp_r.fx) begin
                  $error("force_x expected %0d got %0d", exp_r.fx, rsp.force_x);
                  fail_count++;
               end
               if (rsp.force_y !== exp_r.fy) begin
                  $error("force_y expected %0d got %0d", exp_r.fy, rsp.force_y);
                  fail_count++;
               end
               if (rsp.force_z !== exp_r.fz) begin
                  $error("force_z expected %0d got %0d", exp_r.fz, rsp.force_z);
                  fail_count++;
               end
               if (rsp.in_contact !== exp_r.contact) begin
                  $error("in_contact expected %0d got %0d", exp_r.contact, rsp.in_contact);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            p[0] = longint'(req.pos_x);
            p[1] = longint'(req.pos_y);
            p[2] = longint'(req.pos_z);
            v[0] = longint'(req.vel_x);
            v[1] = longint'(req.vel_y);
            v[2] = longint'(req.vel_z);
            if (req.op == scf_pkg::OP_LOAD) begin
               ref_pos = p;
               ref_vel = v;
               ref_rad = 64'(req.radius);
            end else begin
               expected_forces.push_back(contact_force(p, v, 64'(req.radius)));
            end
         end
      end
      pending = expected_forces.size();
   end

endmodule

// ===== tb/sphere_contact_force_unit_tb.sv =====
// testbench top of the sphere contact force unit: clock, reset, stimulus and verdict
// depends on scf_pkg, scf_chan_if, scf_force_checker and the unit itself
`timescale 1ns / 1ps

module sphere_contact_force_unit_tb;

   localparam logic [scf_pkg::CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic csr_we;
   logic [scf_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [scf_pkg::COEF_BITS-1:0]    csr_wdata;
   int   fail_count;
   int   pending;
   int   burst_left;
   logic long_stall;
   logic [31:0] rx, ry, rz;

   scf_req_if req_bus ();
   scf_rsp_if rsp_bus ();

   sphere_contact_force_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   scf_force_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

   // offer one item and hold it until taken; gaps come between bursts
   task automatic offer_item(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [30:0] rad);
      req_bus.valid  <= 1'b1;
      req_bus.op     <= op;
      req_bus.pos_x  <= px;
      req_bus.pos_y  <= py;
      req_bus.pos_z  <= pz;
      req_bus.vel_x  <= vx;
      req_bus.vel_y  <= vy;
      req_bus.vel_z  <= vz;
      req_bus.radius <= rad;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // hold the sender until every result is in, then let the pipeline drain
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [scf_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [scf_pkg::COEF_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic write_coefs(logic [15:0] sp, logic [15:0] dm, logic [15:0] sh);
      write_reg(scf_pkg::CSR_SPRING, sp);
      write_reg(scf_pkg::CSR_DAMPING, dm);
      write_reg(scf_pkg::CSR_SHEAR, sh);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] near(logic [31:0] base, int span);
      return base + $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   // receiver: randomly chosen stall patterns, and one long hold-off on request
   initial begin
      int mode;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_stall) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_stall = 1'b0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(8, 40)) begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_bus.ready <= ($urandom_range(0, 9) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [15:0] c[3];
      reset         = 1'b1;
      long_stall    = 1'b0;
      burst_left    = 0;
      rx            = '0;
      ry            = '0;
      rz            = '0;
      csr_we        = 1'b0;
      csr_index     = scf_pkg::CSR_SPRING;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.op    = scf_pkg::OP_LOAD;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.vel_x = '0;
      req_bus.vel_y = '0;
      req_bus.vel_z = '0;
      req_bus.radius = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset coefficients
      offer_item(scf_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0);          // coincident, zero radii
      offer_item(scf_pkg::OP_QUERY, 0, 0, 0, 32'h10000, 0, 0, 5);  // coincident, contact
      offer_item(scf_pkg::OP_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
      offer_item(scf_pkg::OP_QUERY, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
      offer_item(scf_pkg::OP_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 0, 32'h7fffffff, 31'h7fffffff);
      offer_item(scf_pkg::OP_QUERY, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0);
      offer_item(scf_pkg::OP_LOAD, 0, 0, 0, 32'h20000, 32'hfffe0000, 32'h8000, 31'h10000);
      offer_item(scf_pkg::OP_QUERY, 32'h18000, 0, 0, 0, 0, 0, 31'h10000);
      offer_item(scf_pkg::OP_QUERY, 32'h30000, 0, 0, 0, 0, 0, 31'h10000);
      offer_item(scf_pkg::OP_QUERY, 32'h20000, 0, 0, 0, 0, 0, 31'h10000);  // just touching
      offer_item(scf_pkg::OP_QUERY, 32'h1ffff, 0, 0, 0, 0, 0, 31'h10000);
      offer_item(scf_pkg::OP_QUERY, 32'hffff0000, 32'h10000, 32'hffff0000, 32'h7fffffff,
                 32'h80000000, 32'h12345, 31'h20000);
      offer_item(scf_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0, 1);
      offer_item(scf_pkg::OP_LOAD, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
      offer_item(scf_pkg::OP_QUERY, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0, 0,
                 31'h7fffffff);
      offer_item(scf_pkg::OP_QUERY, 32'h80000001, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
      drain();

      // coefficient settings: zeros, maxima, defaults, then random ones
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: c = '{16'h0000, 16'h0000, 16'h0000};
            1: c = '{16'hffff, 16'hffff, 16'hffff};
            2: c = '{scf_pkg::SPRING_RESET, scf_pkg::DAMPING_RESET, scf_pkg::SHEAR_RESET};
            default: c = '{16'($urandom), 16'($urandom), 16'($urandom)};
         endcase
         write_coefs(c[0], c[1], c[2]);
         if (phase == 3) begin
            // ignored register index
            csr_we    <= 1'b1;
            csr_index <= CSR_UNUSED;
            csr_wdata <= 16'($urandom);
            @(posedge clock);
            csr_we <= 1'b0;
            @(posedge clock);
         end
         for (int n = 0; n < 172; n++) begin
            if (phase == 1 && n == 40) long_stall = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
               // noise over the full field ranges
               offer_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, 31'($urandom));
            end else if (n % 8 == 0) begin
               rx = $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
               ry = $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
               rz = $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
               offer_item(scf_pkg::OP_LOAD, rx, ry, rz, near(0, 32'h80000),
                          near(0, 32'h80000), near(0, 32'h80000),
                          31'($urandom_range(0, 32'h60000)));
            end else begin
               offer_item(scf_pkg::OP_QUERY, near(rx, 32'h80000), near(ry, 32'h80000),
                          near(rz, 32'h80000), near(0, 32'h80000), near(0, 32'h80000),
                          near(0, 32'h80000), 31'($urandom_range(0, 32'h60000)));
            end
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
